>>> src/ssrch_pkg.sv
// Shared definitions for the streaming substring search.
// Constants, configuration register indexes and the cell control struct.
// No dependencies.
package ssrch_pkg;

  localparam int MAX_PATTERN_DEF = 8;
  localparam int INDEX_BITS_DEF  = 16;

  localparam int PATTERN_W = 64;
  localparam int LENGTH_W  = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

  localparam logic [7:0] TERMINATOR = 8'h00;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

>>> src/ssrch_cell.sv
// One window cell: holds a text byte, passes it on and compares its input byte.
// Depends on ssrch_pkg.
module ssrch_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  ssrch_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          byte_in,
  input  logic [7:0]          want,
  input  logic                en,
  output logic [7:0]          byte_out,
  output logic                match
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.clear) begin
      byte_nxt = 8'h00;
    end else if (ctrl.shift) begin
      byte_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'h00;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_out = byte_r;
  assign match    = !en || (byte_in == want);

endmodule

>>> src/substring_stream_search.sv
// Streaming first-occurrence substring search over zero-terminated strings.
// Depends on ssrch_pkg and ssrch_cell.
//
// Takes one text byte per cycle, back to back while the skid entry is empty,
// and compares the newest MAX_PATTERN bytes against the pattern in parallel
// across a row of window cells. A result (found, match_index) is registered
// from the byte that completes the match or ends the string; a two-entry
// output stage keeps the input open while one result waits. The sustained
// rate is set by the combinational compare across the cell row. Write
// configuration only while no string is being searched.
module substring_stream_search #(
  parameter int MAX_PATTERN = ssrch_pkg::MAX_PATTERN_DEF,
  parameter int INDEX_BITS  = ssrch_pkg::INDEX_BITS_DEF,
  localparam int OUT_W = ((1 + INDEX_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] text_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_W-1:0]               out_tdata,  // [0] found, then match_index
  input  logic                           cfg_we,
  input  logic [ssrch_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssrch_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int RES_W = 1 + INDEX_BITS;

  logic [ssrch_pkg::PATTERN_W-1:0] pattern_r;
  logic [ssrch_pkg::LENGTH_W-1:0]  length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      length_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ssrch_pkg::REG_PATTERN_BYTES:  pattern_r <= cfg_wdata;
        ssrch_pkg::REG_PATTERN_LENGTH: length_r  <= cfg_wdata[ssrch_pkg::LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective length: clamped, cut at the first zero pattern byte
  logic [ssrch_pkg::LENGTH_W-1:0] len_clamp;
  logic [LEN_W-1:0]               eff_len;

  always_comb begin
    len_clamp = length_r;
    if (length_r > ssrch_pkg::LENGTH_W'(MAX_PATTERN)) begin
      len_clamp = ssrch_pkg::LENGTH_W'(MAX_PATTERN);
    end
    eff_len = LEN_W'(len_clamp);
    for (int k = MAX_PATTERN - 1; k >= 0; k--) begin
      if ((ssrch_pkg::LENGTH_W'(k) < len_clamp) && (pattern_r[8*k +: 8] == 8'h00)) begin
        eff_len = LEN_W'(k);
      end
    end
  end

  // cell j sees the byte j steps back and wants pattern byte eff_len-1-j
  logic [7:0] want [MAX_PATTERN];
  logic       en   [MAX_PATTERN];

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      want[j] = 8'h00;
      en[j]   = (LEN_W'(j) < eff_len);
      for (int k = 0; k < MAX_PATTERN; k++) begin
        if (LEN_W'(k + j + 1) == eff_len) begin
          want[j] = pattern_r[8*k +: 8];
        end
      end
    end
  end

  logic                  reported_r;
  logic                  reported_nxt;
  logic [INDEX_BITS-1:0] pos_r;
  logic [INDEX_BITS-1:0] pos_nxt;

  logic       acc;
  logic       term;
  logic       empty_pat;
  ssrch_pkg::cell_ctrl_t ctrl;

  assign acc       = in_tvalid && in_tready;
  assign term      = (in_tdata == ssrch_pkg::TERMINATOR);
  assign empty_pat = (eff_len == '0);

  assign ctrl.shift = acc && !reported_r && !empty_pat && !term;
  assign ctrl.clear = acc && term;

  logic [7:0]             chain [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] match;

  assign chain[0] = in_tdata;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    if (j < MAX_PATTERN - 1) begin : g_mid
      ssrch_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .byte_in  (chain[j]),
        .want     (want[j]),
        .en       (en[j]),
        .byte_out (chain[j+1]),
        .match    (match[j])
      );
    end else begin : g_last
      ssrch_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .byte_in  (chain[j]),
        .want     (want[j]),
        .en       (en[j]),
        .byte_out (),
        .match    (match[j])
      );
    end
  end

  logic [INDEX_BITS-1:0] len_m1;
  logic                  hit;
  logic                  res_valid;
  logic [RES_W-1:0]      res;

  assign len_m1 = INDEX_BITS'(eff_len) - INDEX_BITS'(1);
  assign hit    = !empty_pat && !term && (&match) && (pos_r >= len_m1);

  always_comb begin
    res_valid = acc && !reported_r && (empty_pat || term || hit);
    res       = '0;
    if (empty_pat) begin
      res = RES_W'(1);
    end else if (hit) begin
      res = {pos_r - len_m1, 1'b1};
    end
  end

  always_comb begin
    reported_nxt = reported_r;
    pos_nxt      = pos_r;
    if (acc) begin
      if (term) begin
        reported_nxt = 1'b0;
        pos_nxt      = '0;
      end else if (!reported_r) begin
        reported_nxt = empty_pat || hit;
        if (pos_r != '1) begin
          pos_nxt = pos_r + INDEX_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reported_r <= 1'b0;
      pos_r      <= '0;
    end else begin
      reported_r <= reported_nxt;
      pos_r      <= pos_nxt;
    end
  end

  // output register plus skid entry
  logic             out_valid_r;
  logic [RES_W-1:0] out_data_r;
  logic             skid_valid_r;
  logic [RES_W-1:0] skid_data_r;
  logic             pop;

  assign pop       = out_valid_r && out_tready;
  assign in_tready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (res_valid) begin
      if (out_valid_r && !pop) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

endmodule

>>> test/substring_stream_search_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for substring_stream_search: directed table, then randomised
// pattern settings and strings.
// Depends on ssrch_pkg and the substring_stream_search RTL.
module substring_stream_search_test;

  localparam int MAX_PAT      = ssrch_pkg::MAX_PATTERN_DEF;
  localparam int INDEX_BITS   = ssrch_pkg::INDEX_BITS_DEF;
  localparam int OUT_W        = ((1 + INDEX_BITS + 7) / 8) * 8;
  localparam int TOTAL_ITEMS  = 1950;
  localparam int QUIET_ITEMS  = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int NUM_ROWS     = 30;

  typedef struct packed {
    logic                  found;
    logic [INDEX_BITS-1:0] match_index;
  } search_result_t;

  typedef enum logic {ROW_SETUP, ROW_TEXT} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [63:0]      value;   // pattern for setup rows, text byte in [7:0] otherwise
    logic [3:0]       length;
    logic             typed;
    logic             has_result;
    search_result_t   result;
  } stim_row_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [7:0]                       in_tdata   = 8'h00;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [OUT_W-1:0]                 out_tdata;
  logic                             cfg_we     = 1'b0;
  logic [ssrch_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [ssrch_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;

  substring_stream_search DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [ssrch_pkg::PATTERN_W-1:0] pat_bytes;
  logic [ssrch_pkg::LENGTH_W-1:0]  pat_len;
  logic [55:0]                     text_window;
  logic [INDEX_BITS-1:0]           text_pos;
  logic                            answered;

  search_result_t pending_results [$];
  stim_row_t      directed_rows [NUM_ROWS];

  int  errors       = 0;
  int  results_seen = 0;
  int  items_sent   = 0;
  int  strings_sent = 0;
  int  settings     = 0;
  bit  quiet        = 1'b0;
  bit  hold_req     = 1'b0;
  int  stall_left   = 0;

  function automatic int unsigned eff_len();
    int unsigned n;
    n = pat_len;
    if (n > MAX_PAT) n = MAX_PAT;
    for (int k = 0; k < n; k++)
      if (pat_bytes[8*k +: 8] == ssrch_pkg::TERMINATOR) return k;
    return n;
  endfunction

  function automatic void clear_search();
    text_window = '0;
    text_pos    = '0;
    answered    = 1'b0;
  endfunction

  function automatic bit search_step(input logic [7:0] b, output search_result_t r);
    int unsigned len;
    logic [63:0] comb;
    bit hit;
    len = eff_len();
    r   = '0;
    if (answered) begin
      if (b == ssrch_pkg::TERMINATOR) clear_search();
      return 1'b0;
    end
    if (len == 0) begin
      r.found = 1'b1;
      if (b == ssrch_pkg::TERMINATOR) clear_search();
      else begin
        answered = 1'b1;
        if (text_pos != '1) text_pos++;
      end
      return 1'b1;
    end
    if (b == ssrch_pkg::TERMINATOR) begin
      clear_search();
      return 1'b1;
    end
    comb = {text_window, b};
    hit  = 1'b0;
    if (text_pos >= len - 1) begin
      hit = 1'b1;
      for (int k = 0; k < len; k++)
        if (pat_bytes[8*k +: 8] != comb[8*(len-1-k) +: 8]) hit = 1'b0;
    end
    text_window = comb[55:0];
    if (hit) begin
      r.found       = 1'b1;
      r.match_index = text_pos - INDEX_BITS'(len - 1);
      answered      = 1'b1;
    end
    if (text_pos != '1) text_pos++;
    return hit;
  endfunction

  function automatic logic [7:0] filler_byte();
    logic [7:0] c;
    if ($urandom_range(0, 1)) c = pat_bytes[8*$urandom_range(0, 7) +: 8];
    else c = 8'h61 + 8'($urandom_range(0, 3));
    if (c == ssrch_pkg::TERMINATOR) c = 8'h61;
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b, output bit has, output search_result_t r);
    items_sent++;
    if (b == ssrch_pkg::TERMINATOR) strings_sent++;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    has = search_step(b, r);
  endtask

  task automatic send_text(input logic [7:0] b);
    bit has;
    search_result_t r;
    send_byte(b, has, r);
    if (has) pending_results.push_back(r);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pattern(input logic [63:0] bytes, input logic [3:0] len);
    cfg_we    <= 1'b1;
    cfg_index <= ssrch_pkg::REG_PATTERN_BYTES;
    cfg_wdata <= bytes;
    @(posedge clk);
    cfg_index <= ssrch_pkg::REG_PATTERN_LENGTH;
    cfg_wdata <= ssrch_pkg::CFG_DATA_W'(len);
    @(posedge clk);
    cfg_we    <= 1'b0;
    pat_bytes = bytes;
    pat_len   = len;
    settings++;
  endtask

  // result side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 19) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    search_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: found=%0d index=%0d", out_tdata[0],
                   out_tdata[INDEX_BITS:1]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.found || out_tdata[INDEX_BITS:1] !== want.match_index) begin
          if (errors < 10)
            $display("mismatch: expected found=%0d index=%0d, got found=%0d index=%0d",
                     want.found, want.match_index, out_tdata[0], out_tdata[INDEX_BITS:1]);
          errors++;
        end
      end
    end
  end

  initial begin
    #(64'd6_000_000 * 8);
    $display("FAIL");
    $finish;
  end

  initial begin
    bit has;
    search_result_t r;
    logic [63:0] pat;
    logic [3:0]  len;
    int unsigned plen, mode, lead, cut, sel, target, phase;

    directed_rows = '{
      '{ROW_TEXT,  64'h41, 4'd0, 1'b1, 1'b1, '{1'b1, 16'd0}},
      '{ROW_TEXT,  64'hFF, 4'd0, 1'b1, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'h00, 4'd0, 1'b1, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'h00, 4'd0, 1'b1, 1'b1, '{1'b1, 16'd0}},
      '{ROW_SETUP, 64'h6261, 4'd2, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'h78, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'h61, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'h62, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'h7A, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'h00, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'h71, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'h00, 4'd0, 1'b1, 1'b1, '{1'b0, 16'd0}},
      // length above the maximum, all-ones pattern
      '{ROW_SETUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'h01, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'hFF, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'hFF, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'hFF, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'hFF, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'hFF, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'hFF, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'hFF, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'hFF, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'h00, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      // zero byte inside the pattern shortens it
      '{ROW_SETUP, 64'h43, 4'd5, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'h43, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'h00, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_SETUP, 64'h00, 4'd8, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'h80, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'h00, 4'd0, 1'b0, 1'b0, '{1'b0, 16'd0}},
      '{ROW_TEXT,  64'h00, 4'd0, 1'b1, 1'b1, '{1'b1, 16'd0}}
    };

    pat_bytes = '0;
    pat_len   = '0;
    clear_search();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SETUP) begin
        settle();
        set_pattern(directed_rows[i].value, directed_rows[i].length);
      end else begin
        send_byte(directed_rows[i].value[7:0], has, r);
        if (directed_rows[i].typed) begin
          if (directed_rows[i].has_result) pending_results.push_back(directed_rows[i].result);
        end else if (has) begin
          pending_results.push_back(r);
        end
      end
    end

    target = TOTAL_ITEMS;
    phase  = 0;
    while (items_sent < target) begin
      settle();
      sel = $urandom_range(0, 9);
      case (sel)
        0: begin
          pat = {$urandom, $urandom};
          len = 4'd0;
        end
        1: begin
          pat = '1;
          len = 4'($urandom_range(7, 15));
        end
        2: begin
          pat = {$urandom, $urandom};
          len = 4'($urandom_range(0, 15));
        end
        default: begin
          for (int k = 0; k < 8; k++) pat[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 3));
          if ($urandom_range(0, 7) == 0) pat[8*$urandom_range(0, 7) +: 8] = ssrch_pkg::TERMINATOR;
          len = 4'($urandom_range(1, 8));
        end
      endcase
      set_pattern(pat, len);
      plen = eff_len();
      if (phase == 2) hold_req = 1'b1;
      repeat ($urandom_range(3, 10)) begin
        if (target - items_sent < QUIET_ITEMS) quiet = 1'b1;
        mode = $urandom_range(0, 9);
        lead = (mode == 8) ? 0 : $urandom_range(0, 12);
        for (int i = 0; i < lead; i++)
          send_text(mode == 7 ? 8'($urandom_range(0, 255)) : filler_byte());
        if (mode <= 5 || mode == 9) begin
          if (mode == 9 && plen > 0) repeat ($urandom_range(1, 3)) send_text(pat[7:0]);
          for (int k = 0; k < plen; k++) send_text(pat[8*k +: 8]);
        end else if (mode == 8 && plen > 0) begin
          cut = $urandom_range(0, plen - 1);
          for (int k = 0; k < cut; k++) send_text(pat[8*k +: 8]);
          send_text(pat[8*cut +: 8] ^ 8'(1 << $urandom_range(0, 7)));
        end
        repeat ($urandom_range(0, 6)) send_text(filler_byte());
        send_text(ssrch_pkg::TERMINATOR);
      end
      phase++;
    end

    quiet = 1'b1;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("searched %0d strings (%0d text bytes) under %0d pattern settings,",
             strings_sent, items_sent, settings);
    $display("%0d results checked, with a long result-side hold-off and drained pauses",
             results_seen);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
